@@ rtl/refcounted_id_allocator_top_defines.svh @@
// ----------------------------------------------------------------------------
// refcounted_id_allocator_top_defines
// assertion macros for the allocator rtl
// ----------------------------------------------------------------------------
// every macro samples on the rising edge of clock and is quiet while reset is high
`ifndef REFCOUNTED_ID_ALLOCATOR_TOP_DEFINES_SVH
`define REFCOUNTED_ID_ALLOCATOR_TOP_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define RCIA_ASSERT_NOW(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error(msg);

// condition holds in the cycle after the trigger
`define RCIA_ASSERT_NEXT(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

`endif

@@ rtl/rcia_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcia_pkg
// types and codes shared by the handle allocator front end, engine and top
// ----------------------------------------------------------------------------
package rcia_pkg;

   localparam int OPCODE_W  = 3;
   localparam int ID_W      = 8;
   localparam int AMOUNT_W  = 16;
   localparam int PAYIO_W   = 32;

   localparam logic [OPCODE_W-1:0] OP_ALLOC   = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_INCR    = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_DROP    = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_RELEASE = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_READ    = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_DELETE  = 3'd5;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [ID_W-1:0]     target_id;
      logic [AMOUNT_W-1:0] amount;
      logic [PAYIO_W-1:0]  payload_in;
   } req_type;

   typedef struct packed {
      logic                status;
      logic [ID_W-1:0]     granted_id;
      logic [PAYIO_W-1:0]  payload_out;
   } rsp_type;

   // classified operation, reject covers bad opcodes and ids outside the pool
   typedef enum logic [2:0] {
      K_ALLOC,
      K_INCR,
      K_DROP,
      K_RELEASE,
      K_READ,
      K_DELETE,
      K_REJECT
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [ID_W-1:0]     id;
      logic [AMOUNT_W-1:0] amount;
      logic [PAYIO_W-1:0]  payload;
   } cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } back_state_type;

endpackage

@@ rtl/refcounted_id_allocator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_id_allocator_top
// reference-counted handle allocator with lifo id reuse
// ----------------------------------------------------------------------------
// Each request beat carries one opcode (allocate, increase, drop, release,
// read, delete) and yields exactly one result beat, in order. Requests enter
// a two-entry command queue after decode; the engine takes one command at a
// time, only when idle and the result queue has room: in its idle state it
// reads the use count, payload and reuse stack rams, in its exec state it
// does the read-modify-write and pushes the result into a two-entry result
// queue. No new command is taken before the current one is through.
// No clearing pass is needed after reset, per-id flags live in flip-flops.
module refcounted_id_allocator_top #(
   parameter int NUM_IDS   = 256,
   parameter int PAYLOAD_W = 32,
   parameter int COUNT_W   = 16
) (
   input  logic              clock,
   input  logic              reset,
   // request side
   input  logic              req_push,
   output logic              req_full,
   input  rcia_pkg::req_type req_data,
   // result side
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output rcia_pkg::rsp_type rsp_data
);

   localparam int RSP_W = $bits(rcia_pkg::rsp_type);

   // front to engine
   logic              cmd_empty;
   logic              cmd_pop;
   rcia_pkg::cmd_type cmd_head;

   // engine to result queue
   logic              out_full;
   logic              out_push;
   rcia_pkg::rsp_type out_data;
   logic [RSP_W-1:0]  rsp_vec;

   // decode and command queue
   rcia_front #(
      .NUM_IDS (NUM_IDS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .cmd_pop   (cmd_pop),
      .cmd_empty (cmd_empty),
      .cmd_head  (cmd_head)
   );

   // table engine, owns all per-id state
   rcia_back #(
      .NUM_IDS   (NUM_IDS),
      .PAYLOAD_W (PAYLOAD_W),
      .COUNT_W   (COUNT_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_head  (cmd_head),
      .cmd_pop   (cmd_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_data  (out_data)
   );

   // result queue decouples the engine from a stalled consumer
   rcia_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (2)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .push    (out_push),
      .wr_data (out_data),
      .full    (out_full),
      .pop     (rsp_pop),
      .rd_data (rsp_vec),
      .empty   (rsp_empty)
   );

   assign rsp_data = rcia_pkg::rsp_type'(rsp_vec);

endmodule

@@ rtl/rcia_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcia_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module rcia_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/rcia_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcia_fifo
// small register fifo with push/full and pop/empty sides
// ----------------------------------------------------------------------------
module rcia_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == CW'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      cnt_in = cnt_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

@@ rtl/rcia_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcia_front
// request intake: decodes opcode, checks the id range, queues the command
// ----------------------------------------------------------------------------
module rcia_front #(
   parameter int NUM_IDS = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  rcia_pkg::req_type req_data,
   output logic              req_full,
   input  logic              cmd_pop,
   output logic              cmd_empty,
   output rcia_pkg::cmd_type cmd_head
);

   localparam int CMD_W = $bits(rcia_pkg::cmd_type);

   rcia_pkg::cmd_type cmd_new;
   logic [CMD_W-1:0]  head_vec;
   logic              in_pool;

   assign in_pool = (32'(req_data.target_id) < 32'(NUM_IDS));

   always_comb begin
      cmd_new.id      = req_data.target_id;
      cmd_new.amount  = req_data.amount;
      cmd_new.payload = req_data.payload_in;
      unique case (req_data.opcode)
         rcia_pkg::OP_ALLOC:   cmd_new.kind = rcia_pkg::K_ALLOC;
         rcia_pkg::OP_INCR:    cmd_new.kind = in_pool ? rcia_pkg::K_INCR : rcia_pkg::K_REJECT;
         rcia_pkg::OP_DROP:    cmd_new.kind = in_pool ? rcia_pkg::K_DROP : rcia_pkg::K_REJECT;
         rcia_pkg::OP_RELEASE: cmd_new.kind = in_pool ? rcia_pkg::K_RELEASE
                                                      : rcia_pkg::K_REJECT;
         rcia_pkg::OP_READ:    cmd_new.kind = in_pool ? rcia_pkg::K_READ : rcia_pkg::K_REJECT;
         rcia_pkg::OP_DELETE:  cmd_new.kind = in_pool ? rcia_pkg::K_DELETE
                                                      : rcia_pkg::K_REJECT;
         default:              cmd_new.kind = rcia_pkg::K_REJECT;
      endcase
   end

   rcia_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (2)
   ) u_cmd_q (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .wr_data (cmd_new),
      .full    (req_full),
      .pop     (cmd_pop),
      .rd_data (head_vec),
      .empty   (cmd_empty)
   );

   assign cmd_head = rcia_pkg::cmd_type'(head_vec);

endmodule

@@ rtl/rcia_back.sv @@
`timescale 1ns / 1ps
`include "refcounted_id_allocator_top_defines.svh"
// ----------------------------------------------------------------------------
// rcia_back
// execution engine: reads per-id tables, then updates them and emits a result
// ----------------------------------------------------------------------------
module rcia_back #(
   parameter int NUM_IDS   = 256,
   parameter int PAYLOAD_W = 32,
   parameter int COUNT_W   = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_empty,
   input  rcia_pkg::cmd_type cmd_head,
   output logic              cmd_pop,
   input  logic              out_full,
   output logic              out_push,
   output rcia_pkg::rsp_type out_data
);

   // only ids below 256 can be targeted, so tables cover at most that many
   localparam int TBL = (NUM_IDS < 256) ? NUM_IDS : 256;
   localparam int TIW = $clog2(TBL);
   localparam int SPW = $clog2(TBL + 1);
   localparam int FRW = $clog2(NUM_IDS + 1);
   localparam int IDW = $clog2(NUM_IDS);
   localparam int SW  = ((COUNT_W > rcia_pkg::AMOUNT_W) ? COUNT_W : rcia_pkg::AMOUNT_W) + 1;
   localparam logic [COUNT_W-1:0] CNT_MAX = '1;

   rcia_pkg::back_state_type state_ff, state_in;
   rcia_pkg::cmd_type        cmd_ff, cmd_in;
   logic [TBL-1:0]           has_ff, has_in;
   logic [TBL-1:0]           cvld_ff, cvld_in;
   logic [SPW-1:0]           sp_ff, sp_in, sp_dec;
   logic [FRW-1:0]           fresh_ff, fresh_in;

   logic                 tbl_rd;
   logic [TIW-1:0]       idx;
   logic                 cnt_we;
   logic [COUNT_W-1:0]   cnt_wdata, cnt_rdata, cnt_cur;
   logic                 pay_we;
   logic [TIW-1:0]       pay_waddr;
   logic [PAYLOAD_W-1:0] pay_wdata, pay_rdata;
   logic                 stk_we;
   logic [TIW-1:0]       stk_wdata, stk_rdata;

   logic                 has_cur;
   logic [SW-1:0]        cnt_x, amt_x, sum_x, dif_x;
   logic                 from_stack, fresh_ok, alloc_in_tbl;
   logic [IDW-1:0]       alloc_id;
   logic                 push_req;

   assign idx          = cmd_ff.id[TIW-1:0];
   assign cnt_cur      = cvld_ff[idx] ? cnt_rdata : '0;
   assign has_cur      = has_ff[idx];
   assign cnt_x        = SW'(cnt_cur);
   assign amt_x        = SW'(cmd_ff.amount);
   assign sum_x        = cnt_x + amt_x;
   assign dif_x        = cnt_x - amt_x;
   assign sp_dec       = sp_ff - SPW'(1);
   assign from_stack   = (sp_ff != '0);
   assign fresh_ok     = (fresh_ff < FRW'(NUM_IDS));
   assign alloc_id     = from_stack ? IDW'(stk_rdata) : fresh_ff[IDW-1:0];
   assign alloc_in_tbl = ({1'b0, alloc_id} < (IDW + 1)'(TBL));

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      has_in    = has_ff;
      cvld_in   = cvld_ff;
      sp_in     = sp_ff;
      fresh_in  = fresh_ff;
      cmd_pop   = 1'b0;
      tbl_rd    = 1'b0;
      out_push  = 1'b0;
      out_data.status      = rcia_pkg::STATUS_FAIL;
      out_data.granted_id  = '0;
      out_data.payload_out = '0;
      cnt_we    = 1'b0;
      cnt_wdata = '0;
      pay_we    = 1'b0;
      pay_waddr = idx;
      pay_wdata = PAYLOAD_W'(cmd_ff.payload);
      stk_we    = 1'b0;
      stk_wdata = idx;
      push_req  = 1'b0;
      unique case (state_ff)
         rcia_pkg::ST_IDLE: begin
            if (!cmd_empty && !out_full) begin
               cmd_pop  = 1'b1;
               tbl_rd   = 1'b1;
               cmd_in   = cmd_head;
               state_in = rcia_pkg::ST_EXEC;
            end
         end
         rcia_pkg::ST_EXEC: begin
            state_in = rcia_pkg::ST_IDLE;
            out_push = 1'b1;
            unique case (cmd_ff.kind)
               rcia_pkg::K_ALLOC: begin
                  if (from_stack || fresh_ok) begin
                     out_data.status     = rcia_pkg::STATUS_OK;
                     out_data.granted_id = rcia_pkg::ID_W'(alloc_id);
                     if (from_stack) begin
                        sp_in = sp_dec;
                     end else begin
                        fresh_in = fresh_ff + FRW'(1);
                     end
                     if (alloc_in_tbl) begin
                        pay_we    = 1'b1;
                        pay_waddr = alloc_id[TIW-1:0];
                        has_in[alloc_id[TIW-1:0]] = 1'b1;
                     end
                  end
               end
               rcia_pkg::K_INCR: begin
                  if (has_cur) begin
                     out_data.status = rcia_pkg::STATUS_OK;
                     cnt_we       = 1'b1;
                     cnt_wdata    = (sum_x > SW'(CNT_MAX)) ? CNT_MAX : sum_x[COUNT_W-1:0];
                     cvld_in[idx] = 1'b1;
                  end
               end
               rcia_pkg::K_DROP: begin
                  if (cnt_x >= amt_x) begin
                     out_data.status = rcia_pkg::STATUS_OK;
                     cnt_we       = 1'b1;
                     cnt_wdata    = dif_x[COUNT_W-1:0];
                     cvld_in[idx] = 1'b1;
                     push_req     = !has_cur && (cnt_cur != '0) && (dif_x == '0);
                  end
               end
               rcia_pkg::K_RELEASE: begin
                  if (has_cur || (cnt_cur != '0)) begin
                     out_data.status = rcia_pkg::STATUS_OK;
                     has_in[idx]  = 1'b0;
                     cvld_in[idx] = 1'b0;
                     push_req     = 1'b1;
                  end
               end
               rcia_pkg::K_READ: begin
                  if (has_cur) begin
                     out_data.status      = rcia_pkg::STATUS_OK;
                     out_data.payload_out = rcia_pkg::PAYIO_W'(pay_rdata);
                  end
               end
               rcia_pkg::K_DELETE: begin
                  if (has_cur) begin
                     out_data.status = rcia_pkg::STATUS_OK;
                     has_in[idx]     = 1'b0;
                  end
               end
               default: begin
               end
            endcase
            if (push_req && (sp_ff != SPW'(TBL))) begin
               stk_we = 1'b1;
               sp_in  = sp_ff + SPW'(1);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rcia_pkg::ST_IDLE;
         has_ff   <= '0;
         cvld_ff  <= '0;
         sp_ff    <= '0;
         fresh_ff <= '0;
      end else begin
         state_ff <= state_in;
         has_ff   <= has_in;
         cvld_ff  <= cvld_in;
         sp_ff    <= sp_in;
         fresh_ff <= fresh_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

   rcia_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (TBL)
   ) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (idx),
      .wr_data (cnt_wdata),
      .rd_en   (tbl_rd),
      .rd_addr (cmd_head.id[TIW-1:0]),
      .rd_data (cnt_rdata)
   );

   rcia_ram #(
      .WIDTH (PAYLOAD_W),
      .DEPTH (TBL)
   ) u_pay_ram (
      .clock   (clock),
      .wr_en   (pay_we),
      .wr_addr (pay_waddr),
      .wr_data (pay_wdata),
      .rd_en   (tbl_rd),
      .rd_addr (cmd_head.id[TIW-1:0]),
      .rd_data (pay_rdata)
   );

   rcia_ram #(
      .WIDTH (TIW),
      .DEPTH (TBL)
   ) u_stk_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (sp_ff[TIW-1:0]),
      .wr_data (stk_wdata),
      .rd_en   (tbl_rd),
      .rd_addr (sp_dec[TIW-1:0]),
      .rd_data (stk_rdata)
   );

   `RCIA_ASSERT_NEXT(a_exec_one_cycle, state_ff == rcia_pkg::ST_EXEC,
                     state_ff == rcia_pkg::ST_IDLE, "engine stayed in exec")
   `RCIA_ASSERT_NOW(a_exec_has_room, state_ff == rcia_pkg::ST_EXEC, !out_full,
                    "result queue full at exec")
   `RCIA_ASSERT_NOW(a_sp_bound, 1'b1, sp_ff <= SPW'(TBL), "reuse stack pointer past depth")
   `RCIA_ASSERT_NEXT(a_pushed_id_clean, stk_we,
                     !has_ff[$past(idx)] && !cvld_ff[$past(idx)]
                     || $past(cmd_ff.kind) == rcia_pkg::K_DROP,
                     "recycled id still owns data")

endmodule
